// ----- design/fcc_pkg.sv -----
// Shared types, constants and checksum helpers for the frame checksum checker.
package fcc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SUM_W   = 16;
    localparam int unsigned COUNT_W = 2;

    localparam logic [COUNT_W-1:0] HELD_FULL = COUNT_W'(2);
    localparam logic [SUM_W-1:0]   SUM_MASK  = 16'hFFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last_byte;
    } t_in_word;

    typedef struct packed {
        logic [SUM_W-1:0] checksum_computed;
        logic [SUM_W-1:0] checksum_received;
        logic             match_direct;
        logic             match_swapped;
        logic             frame_short;
    } t_out_word;

    function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] full;
        full = {1'b0, a} + {1'b0, b};
        return full[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, full[SUM_W]};
    endfunction

    function automatic logic [SUM_W-1:0] swap16(input logic [SUM_W-1:0] v);
        return {v[BYTE_W-1:0], v[SUM_W-1:BYTE_W]};
    endfunction

endpackage

// ----- design/fcc_core.sv -----
// Frame state: two-byte delay line, byte pairing, running sum and result logic.
module fcc_core
    import fcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_in_word  i_word,
    output t_out_word o_result
);

    logic [SUM_W-1:0]   r_held_bytes, n_held_bytes;
    logic [COUNT_W-1:0] r_held_count, n_held_count;
    logic [BYTE_W-1:0]  r_pending_low, n_pending_low;
    logic               r_pair_phase, n_pair_phase;
    logic [SUM_W-1:0]   r_running_sum, n_running_sum;

    logic [SUM_W-1:0] final_sum;
    logic [SUM_W-1:0] computed;
    logic             short_frame;
    logic             direct;

    always_comb begin
        n_held_bytes  = r_held_bytes;
        n_held_count  = r_held_count;
        n_pending_low = r_pending_low;
        n_pair_phase  = r_pair_phase;
        n_running_sum = r_running_sum;
        if (i_take) begin
            if (i_word.last_byte) begin
                n_held_bytes  = '0;
                n_held_count  = '0;
                n_pending_low = '0;
                n_pair_phase  = 1'b0;
                n_running_sum = '0;
            end else begin
                if (r_held_count >= HELD_FULL) begin
                    if (!r_pair_phase) begin
                        n_pending_low = r_held_bytes[BYTE_W-1:0];
                        n_pair_phase  = 1'b1;
                    end else begin
                        n_running_sum = sum_add(r_running_sum,
                                                {r_held_bytes[BYTE_W-1:0], r_pending_low});
                        n_pair_phase  = 1'b0;
                    end
                end else begin
                    n_held_count = r_held_count + COUNT_W'(1);
                end
                n_held_bytes = {i_word.frame_byte, r_held_bytes[SUM_W-1:BYTE_W]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bytes  <= '0;
            r_held_count  <= '0;
            r_pending_low <= '0;
            r_pair_phase  <= 1'b0;
            r_running_sum <= '0;
        end else begin
            r_held_bytes  <= n_held_bytes;
            r_held_count  <= n_held_count;
            r_pending_low <= n_pending_low;
            r_pair_phase  <= n_pair_phase;
            r_running_sum <= n_running_sum;
        end
    end

    always_comb begin
        final_sum   = r_pair_phase
                    ? sum_add(r_running_sum, {{BYTE_W{1'b0}}, r_pending_low})
                    : r_running_sum;
        computed    = swap16((final_sum ^ SUM_MASK) + SUM_W'(1));
        short_frame = (r_held_count < HELD_FULL);
        direct      = (computed == r_held_bytes);
        if (short_frame) begin
            o_result = '0;
            o_result.frame_short = 1'b1;
        end else begin
            o_result.checksum_computed = computed;
            o_result.checksum_received = r_held_bytes;
            o_result.match_direct      = direct;
            o_result.match_swapped     = !direct && (computed == swap16(r_held_bytes));
            o_result.frame_short       = 1'b0;
        end
    end

endmodule

// ----- design/frame_checksum_checker.sv -----
// Top level of the frame checksum checker: word handshake and result register.
// Result word is registered, valid the cycle after its stop byte is accepted.
// Throughput: one byte word per cycle while ready is high; between registers the
// state update uses one 16-bit end-around-carry adder, result logic one and a +1.
// Ready drops only while a result word is held and the output is stalled.
// Reset (synchronous, active low) clears the frame state and the output valid.
module frame_checksum_checker
    import fcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic      take;
    t_out_word result;
    logic      r_out_valid;
    t_out_word r_out_word;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign take       = i_in_valid && o_in_ready;

    fcc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_word   (i_in_word),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && i_in_word.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in_word.last_byte) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_rise_from_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(take && i_in_word.last_byte))
        else $error("result word without a stop byte");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.frame_short) |->
        (o_out_word.checksum_computed == '0 && o_out_word.checksum_received == '0
         && !o_out_word.match_direct && !o_out_word.match_swapped))
        else $error("short frame result not cleared");

    a_match_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.match_direct && o_out_word.match_swapped))
        else $error("both match flags set");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule
